@@ hw/rtl/cdd_pkg.sv @@
// Package: shared types, constants and calendar tables for the date check and difference block.
package cdd_pkg;

    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 14;
    localparam int StatW  = 2;
    localparam int NumW   = 22;

    localparam logic [YearW-1:0] YEAR_MAX = YearW'(9999);

    // Reciprocals for division by 100 and 400 on 15-bit operands, shift of 22.
    localparam int          RecipShift = 22;
    localparam int          ProdW      = 31;
    localparam logic [15:0] RECIP_100  = 16'd41944;
    localparam logic [15:0] RECIP_400  = 16'd10486;
    localparam int          Q100W      = 8;
    localparam int          Q400W      = 6;
    localparam int          PartW      = 13;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_YEAR  = 2'd1,
        ST_BAD_MONTH = 2'd2,
        ST_BAD_DAY   = 2'd3
    } t_status;

    typedef struct packed {
        logic [DayW-1:0]   day_first;
        logic [MonthW-1:0] month_first;
        logic [YearW-1:0]  year_first;
        logic [DayW-1:0]   day_second;
        logic [MonthW-1:0] month_second;
        logic [YearW-1:0]  year_second;
    } t_dates_in;

    typedef struct packed {
        logic [StatW-1:0] status_first;
        logic [StatW-1:0] status_second;
        logic [NumW-1:0]  day_difference;
    } t_diff_out;

    // Days before the first of the month in a common year.
    function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length in a common year.
    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m);
        logic [DayW-1:0] r;
        case (m)
            4'd2:                      r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/cdd_date.sv @@
// Three-stage day number and validity unit for one calendar date.
module cdd_date
    import cdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DayW-1:0]   i_day,
    input  logic [MonthW-1:0] i_month,
    input  logic [YearW-1:0]  i_year,
    output t_status           o_status,
    output logic [NumW-1:0]   o_num
);

    // Stage 1: operands and quotients from reciprocal multiplies
    logic [DayW-1:0]   r_d1;
    logic [MonthW-1:0] r_m1;
    logic [YearW-1:0]  r_y1;
    logic [Q100W-1:0]  r_fl100, r_ce100;
    logic [Q400W-1:0]  r_fl400, r_ce400;

    logic [14:0]      n_y15, n_y99, n_y399;
    logic [ProdW-1:0] n_pf100, n_pc100, n_pf400, n_pc400;

    always_comb begin
        n_y15   = 15'(i_year);
        n_y99   = n_y15 + 15'd99;
        n_y399  = n_y15 + 15'd399;
        n_pf100 = ProdW'(n_y15)  * ProdW'(RECIP_100);
        n_pc100 = ProdW'(n_y99)  * ProdW'(RECIP_100);
        n_pf400 = ProdW'(n_y15)  * ProdW'(RECIP_400);
        n_pc400 = ProdW'(n_y399) * ProdW'(RECIP_400);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1    <= i_day;
            r_m1    <= i_month;
            r_y1    <= i_year;
            r_fl100 <= n_pf100[RecipShift +: Q100W];
            r_ce100 <= n_pc100[RecipShift +: Q100W];
            r_fl400 <= n_pf400[RecipShift +: Q400W];
            r_ce400 <= n_pc400[RecipShift +: Q400W];
        end
    end

    // Stage 2: leap test, status, year days and the small part of the day number
    t_status          r_st2;
    logic [NumW-1:0]  r_y365;
    logic [PartW-1:0] r_part;

    logic             n_leap;
    logic [PartW-1:0] n_leaps, n_part;
    logic [DayW-1:0]  n_len;
    t_status          n_st;
    logic [22:0]      n_prod365;

    always_comb begin
        // ceil equals floor exactly when the year is a multiple
        n_leap  = (r_ce400 == r_fl400) ||
                  ((r_y1[1:0] == 2'd0) && (r_ce100 != r_fl100));
        n_leaps = PartW'((15'(r_y1) + 15'd3) >> 2) - PartW'(r_ce100) + PartW'(r_ce400);
        n_part  = n_leaps + PartW'(days_before_month(r_m1)) + PartW'(r_d1)
                + PartW'((r_m1 > 4'd2) && n_leap);
        n_prod365 = 23'(r_y1) * 23'(DAYS_PER_YEAR);

        n_len = month_length(r_m1);
        if ((r_m1 == 4'd2) && n_leap) begin
            n_len = 5'd29;
        end

        if (r_y1 > YEAR_MAX) begin
            n_st = ST_BAD_YEAR;
        end else if (!(r_m1 inside {[4'd1:4'd12]})) begin
            n_st = ST_BAD_MONTH;
        end else if ((r_d1 == 5'd0) || (r_d1 > n_len)) begin
            n_st = ST_BAD_DAY;
        end else begin
            n_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st2  <= n_st;
            r_y365 <= n_prod365[NumW-1:0];
            r_part <= n_part;
        end
    end

    // Stage 3: full day number
    t_status         r_st3;
    logic [NumW-1:0] r_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st3 <= r_st2;
            r_num <= r_y365 + NumW'(r_part);
        end
    end

    assign o_status = r_st3;
    assign o_num    = r_num;

endmodule

@@ hw/rtl/calendar_date_check_and_difference_top.sv @@
// Top level: Gregorian date check and absolute day difference, four-stage pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------
//  dates   | in        | i_valid / o_stall     | i_data (t_dates_in)
//  result  | out       | o_valid / i_stall     | o_data (t_diff_out)
//
// One beat per cycle unless a held result stalls the pipeline.
// Both dates run through their own three-stage day number units; the fourth stage
// takes the absolute difference into the output register.
// Reset clears the valid bits only. A held output stalls every stage at once, so
// o_stall is high exactly while a result waits and i_stall is high.
module calendar_date_check_and_difference_top
    import cdd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_dates_in i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_diff_out o_data
);

    logic r_v1, r_v2, r_v3, r_ov;
    logic n_en;

    assign n_en    = !(r_ov && i_stall);
    assign o_stall = !n_en;

    t_status         n_st_a, n_st_b;
    logic [NumW-1:0] n_num_a, n_num_b;

    cdd_date u_date_a (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_day    (i_data.day_first),
        .i_month  (i_data.month_first),
        .i_year   (i_data.year_first),
        .o_status (n_st_a),
        .o_num    (n_num_a)
    );

    cdd_date u_date_b (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_day    (i_data.day_second),
        .i_month  (i_data.month_second),
        .i_year   (i_data.year_second),
        .o_status (n_st_b),
        .o_num    (n_num_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Stage 4: absolute difference, dropped to zero when either date is bad
    t_diff_out       r_out;
    logic [NumW-1:0] n_diff;

    always_comb begin
        if ((n_st_a != ST_OK) || (n_st_b != ST_OK)) begin
            n_diff = '0;
        end else if (n_num_a > n_num_b) begin
            n_diff = n_num_a - n_num_b;
        end else begin
            n_diff = n_num_b - n_num_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out.status_first   <= n_st_a;
            r_out.status_second  <= n_st_b;
            r_out.day_difference <= n_diff;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

@@ hw/rtl/cdd_checker.sv @@
// Port-level checker for the date check and difference block, with its bind.
module cdd_checker
    import cdd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_dates_in i_data,
    input logic      o_valid,
    input logic      i_stall,
    input t_diff_out o_data
);

    // A bad date forces a zero difference
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_data.status_first != ST_OK) || (o_data.status_second != ST_OK))
        |-> (o_data.day_difference == '0))
        else $error("difference not zero for a bad date");

    // Difference stays within the span of the calendar
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.day_difference <= NumW'(3652424)))
        else $error("difference out of range");

    // Input stalls only behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // Empty output register never blocks the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // Held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

endmodule

bind calendar_date_check_and_difference_top cdd_checker u_cdd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
